// ===== design/sti_pkg.sv =====
`default_nettype none
package sti_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// operation broadcast to every cell
	typedef struct packed {
		logic               ins_en;
		logic               del_en;
		logic signed [31:0] value;
	} sti_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic               occ;
		logic               gt;
		logic signed [31:0] value;
	} sti_link_t;

	// next state of a cell, used for the head of the table
	typedef struct packed {
		logic               occ;
		logic signed [31:0] value;
	} sti_next_t;

endpackage
`default_nettype wire

// ===== design/sti_cell.sv =====
`default_nettype none
module sti_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sti_pkg::sti_cmd_t  cmd,
	input  wire sti_pkg::sti_link_t left_link,
	input  wire sti_pkg::sti_link_t right_link,
	output sti_pkg::sti_link_t      link,
	output sti_pkg::sti_next_t      nxt,
	output logic                   eq
);
	import sti_pkg::*;

	logic               occ_q;
	logic signed [31:0] value_q;
	logic               gt;
	logic               ge;

	// empty cells count as larger than anything
	assign gt = !occ_q || (value_q > cmd.value);
	assign ge = occ_q && !(cmd.value > value_q);
	assign eq = occ_q && (value_q == cmd.value);

	assign link.occ   = occ_q;
	assign link.gt    = gt;
	assign link.value = value_q;

	always_comb begin
		nxt.occ   = occ_q;
		nxt.value = value_q;
		if (cmd.ins_en && gt) begin
			// shift right from the insert point on
			nxt.occ   = left_link.gt ? left_link.occ : 1'b1;
			nxt.value = left_link.gt ? left_link.value : cmd.value;
		end else if (cmd.del_en && ge) begin
			// first equal entry and everything above moves down
			nxt.occ   = right_link.occ;
			nxt.value = right_link.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= nxt.occ;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt.value;
	end

endmodule
`default_nettype wire

// ===== design/sorted_table_insert_delete.sv =====
// Sorted table of signed 32-bit values held in a row of TABLE_DEPTH cells, cell 0 holding the
// smallest entry. Each request (action 0 insert after equal entries, action 1 delete the first
// equal entry) goes to all cells at once: each compares its entry with the request value and
// takes its own, its left or its right neighbor's entry. A new request can be accepted every
// cycle unless stalled; its result (status, entry count, smallest entry or 0 when empty)
// appears in the cycle after acceptance in an output register and holds while out_stall is high.
// in_stall is raised only while a result waits in that register and is stalled. entry_count
// shows the low 5 bits of the count. The table is empty after reset; no clearing pass.
`default_nettype none
module sorted_table_insert_delete #(
	parameter int TABLE_DEPTH = sti_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [4:0]              entry_count,
	output logic signed [31:0]      smallest_value
);
	import sti_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam sti_link_t HEAD_LINK = '{occ: 1'b1, gt: 1'b0, value: 32'sd0};
	localparam sti_link_t TAIL_LINK = '{occ: 1'b0, gt: 1'b1, value: 32'sd0};

	sti_cmd_t              cmd;
	sti_link_t             links [TABLE_DEPTH];
	sti_next_t             nxts  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] eq_vec;
	logic [TABLE_DEPTH-1:0] occ_vec;

	logic          accept;
	logic          full;
	logic          found;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [1:0]    status_d;
	logic [31:0]   count_wide;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [4:0]         entry_count_q;
	logic signed [31:0] smallest_q;

	assign accept = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;

	assign full  = occ_vec[TABLE_DEPTH-1];
	assign found = |eq_vec;

	assign cmd.ins_en = accept && (action == ACT_INSERT) && !full;
	assign cmd.del_en = accept && (action == ACT_DELETE) && found;
	assign cmd.value  = value;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		sti_link_t left_l;
		sti_link_t right_l;
		if (i == 0) begin : g_head
			assign left_l = HEAD_LINK;
		end else begin : g_body
			assign left_l = links[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign right_l = TAIL_LINK;
		end else begin : g_mid
			assign right_l = links[i+1];
		end
		sti_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_link  (left_l),
			.right_link (right_l),
			.link       (links[i]),
			.nxt        (nxts[i]),
			.eq         (eq_vec[i])
		);
		assign occ_vec[i] = links[i].occ;
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_DONE;
		if (action == ACT_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else begin
			if (!found) begin
				status_d = ST_NOT_FOUND;
			end else begin
				count_d = count_q - CW'(1);
			end
		end
	end

	assign count_wide = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			entry_count_q <= count_wide[4:0];
			smallest_q    <= nxts[0].occ ? nxts[0].value : 32'sd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_count    = entry_count_q;
	assign smallest_value = smallest_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == 32'($countones(occ_vec)))
		else $error("count does not match occupied cells");

	a_head_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		occ_vec[0] == (count_q != '0))
		else $error("head cell occupancy disagrees with count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_en |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the table");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request produced no result");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
	import sti_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] head;
	} table_reply_t;

	// shadow copy of the sorted table plus the replies still owed by the block
	class table_scoreboard;
		logic signed [31:0] shadow[$];
		table_reply_t       owed[$];
		int                 mismatches;
		int                 seen;

		function new();
			mismatches = 0;
			seen = 0;
		endfunction

		function void note_request(logic act, logic signed [31:0] val);
			int pos;
			table_reply_t r;
			r.status = ST_DONE;
			if (act == ACT_INSERT) begin
				if (shadow.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// goes after every equal entry
					pos = 0;
					while (pos < shadow.size() && !(shadow[pos] > val))
						pos++;
					shadow.insert(pos, val);
				end
			end else begin
				pos = 0;
				while (pos < shadow.size() && shadow[pos] != val)
					pos++;
				if (pos >= shadow.size())
					r.status = ST_NOT_FOUND;
				else
					shadow.delete(pos);
			end
			r.count = 5'(shadow.size());
			r.head = (shadow.size() > 0) ? shadow[0] : 32'sd0;
			owed.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [4:0] cnt, logic signed [31:0] head);
			table_reply_t e;
			seen++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: status %0d count %0d head %0d", st, cnt, head);
			end else begin
				e = owed.pop_front();
				if (e.status !== st || e.count !== cnt || e.head !== head) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply %0d: expected status %0d count %0d head %0d, got %0d %0d %0d",
							seen, e.status, e.count, e.head, st, cnt, head);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               action;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic signed [31:0] smallest_value;

	table_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_done;
	int quiet_cycles;

	sorted_table_insert_delete #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_count(entry_count),
		.smallest_value(smallest_value)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver: checks replies and stalls at random, with one long hold-off late in the run
	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(status, entry_count, smallest_value);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && sb.seen >= 1200) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic offer_request(input logic act, input logic signed [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= val;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(act, val);
	endtask

	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = $signed(32'($urandom_range(6))) - 32'sd3;
			5: begin
				case ($urandom_range(3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = VAL_MIN + 32'sd1;
					default: v = VAL_MAX - 32'sd1;
				endcase
			end
			default: v = $signed($urandom());
		endcase
		return v;
	endfunction

	task automatic random_request(input int n);
		int ins_pct;
		logic act;
		logic signed [31:0] val;
		// alternate bias so the table swings between empty and full
		ins_pct = ((n / 40) % 2 == 0) ? 75 : 25;
		if ($urandom_range(99) < 5) begin
			act = 1'($urandom_range(1));
			val = $signed($urandom());
		end else if ($urandom_range(99) < ins_pct) begin
			act = ACT_INSERT;
			val = pick_value();
		end else begin
			act = ACT_DELETE;
			if (sb.shadow.size() > 0 && $urandom_range(99) < 70)
				val = sb.shadow[$urandom_range(sb.shadow.size() - 1)];
			else
				val = pick_value();
		end
		offer_request(act, val);
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_INSERT;
		value <= 32'sd0;
		quiet_cycles = 0;
		send_idle_pct = 36;
		recv_idle_pct = 82;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// delete on empty table, extremes, duplicates, absent value
		offer_request(ACT_DELETE, 32'sd5);
		offer_request(ACT_INSERT, VAL_MAX);
		offer_request(ACT_INSERT, VAL_MIN);
		offer_request(ACT_INSERT, 32'sd0);
		offer_request(ACT_INSERT, -32'sd1);
		offer_request(ACT_INSERT, 32'sd0);
		offer_request(ACT_DELETE, 32'sd0);
		offer_request(ACT_DELETE, 32'sd7);
		// fill up, then insert into a full table
		for (int i = 0; i < 12; i++)
			offer_request(ACT_INSERT, $signed(32'(i)) - 32'sd6);
		offer_request(ACT_INSERT, 32'sd42);
		offer_request(ACT_DELETE, VAL_MIN);
		offer_request(ACT_DELETE, VAL_MAX);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 500; n++)
				random_request(n);
		end
		in_valid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
